[rtl/core/rse_pkg.sv]
package rse_pkg;

    // token characters
    localparam logic [7:0] TOK_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] TOK_NINE  = 8'h39;  // '9'
    localparam logic [7:0] TOK_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] TOK_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] TOK_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] TOK_SLASH = 8'h2F;  // '/'

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_DIVZ    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic hit;   // result was clamped
        logic divz;  // zero divisor
    } t_alu_rsp;

    typedef struct packed {
        logic        hit;
        logic [31:0] val;
    } t_sat;

    localparam logic signed [64:0] SAT_MAX = 65'sh0_7FFF_FFFF;
    localparam logic signed [64:0] SAT_MIN = -65'sh0_8000_0000;

    // clamp a wide signed value into the 32-bit signed range
    function automatic t_sat sat32(input logic signed [64:0] v);
        t_sat s;
        s.hit = 1'b0;
        s.val = v[31:0];
        if (v > SAT_MAX) begin
            s.hit = 1'b1;
            s.val = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            s.hit = 1'b1;
            s.val = 32'h8000_0000;
        end
        return s;
    endfunction

endpackage

[rtl/core/rse_if.sv]
interface rse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] token;
    logic       last;

    modport source (output valid, output token, output last, input ready);
    modport sink   (input valid, input token, input last, output ready);
endinterface

interface rse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               saturated;

    modport source (output valid, output value, output status, output saturated, input ready);
    modport sink   (input valid, input value, input status, input saturated, output ready);
endinterface

[rtl/core/rse_ram.sv]
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rse_alu.sv]
module rse_alu
    import rse_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_alu_req           i_req,
    input  logic signed [31:0] i_a,      // first popped (top)
    input  logic signed [31:0] i_b,      // second popped
    output t_alu_rsp           o_rsp,
    output logic [31:0]        o_result
);

    localparam int NW  = 32 + FRAC_BITS;    // dividend width
    localparam int DCW = $clog2(NW + 1);

    localparam logic [2:0] AS_IDLE = 3'd0;
    localparam logic [2:0] AS_SUM  = 3'd1;
    localparam logic [2:0] AS_MUL  = 3'd2;
    localparam logic [2:0] AS_MULS = 3'd3;
    localparam logic [2:0] AS_DIV  = 3'd4;
    localparam logic [2:0] AS_DIVF = 3'd5;

    logic [2:0]         r_st;
    logic               r_done;
    logic               r_hit;
    logic               r_divz;
    logic [31:0]        r_res;
    t_op                r_op;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_prod;
    logic [31:0]        r_rem;
    logic [NW-1:0]      r_q;
    logic [31:0]        r_d;
    logic               r_neg;
    logic [DCW-1:0]     r_cnt;

    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic signed [64:0] sum;
    logic signed [64:0] prod_sc;
    logic signed [64:0] quot;
    logic [64:0]        q_ext;
    logic [32:0]        rem_sh;
    logic               ge;
    t_sat               sat_sum;
    t_sat               sat_mul;
    t_sat               sat_div;

    assign abs_a = i_a[31] ? (~i_a + 32'd1) : i_a;
    assign abs_b = i_b[31] ? (~i_b + 32'd1) : i_b;

    assign sum = (r_op == OP_SUB) ? (65'(r_b) - 65'(r_a)) : (65'(r_b) + 65'(r_a));
    // arithmetic shift floors toward minus infinity
    assign prod_sc = 65'(r_prod >>> FRAC_BITS);
    assign q_ext   = 65'(r_q);
    assign quot    = r_neg ? -$signed(q_ext) : $signed(q_ext);

    // restoring divide, one quotient bit per cycle; remainder stays below the divisor
    assign rem_sh = {r_rem, r_q[NW-1]};
    assign ge     = (rem_sh >= {1'b0, r_d});

    assign sat_sum = sat32(sum);
    assign sat_mul = sat32(prod_sc);
    assign sat_div = sat32(quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= AS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                AS_IDLE: begin
                    if (i_req.start) begin
                        case (i_req.op)
                            OP_ADD:  r_st <= AS_SUM;
                            OP_SUB:  r_st <= AS_SUM;
                            OP_MUL:  r_st <= AS_MUL;
                            default: r_st <= AS_DIV;
                        endcase
                    end
                end
                AS_SUM: begin
                    r_done <= 1'b1;
                    r_st   <= AS_IDLE;
                end
                AS_MUL: begin
                    r_st <= AS_MULS;
                end
                AS_MULS: begin
                    r_done <= 1'b1;
                    r_st   <= AS_IDLE;
                end
                AS_DIV: begin
                    if (r_divz) begin
                        r_done <= 1'b1;
                        r_st   <= AS_IDLE;
                    end else if (r_cnt == DCW'(1)) begin
                        r_st <= AS_DIVF;
                    end
                end
                AS_DIVF: begin
                    r_done <= 1'b1;
                    r_st   <= AS_IDLE;
                end
                default: r_st <= AS_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_st)
            AS_IDLE: begin
                if (i_req.start) begin
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_op  <= i_req.op;
                    r_divz <= (i_req.op == OP_DIV) && (i_a == 32'sd0);
                    r_d   <= abs_a;
                    r_neg <= i_a[31] ^ i_b[31];
                    r_rem <= '0;
                    r_q   <= NW'(abs_b) << FRAC_BITS;
                    r_cnt <= DCW'(NW);
                end
            end
            AS_SUM: begin
                r_res <= sat_sum.val;
                r_hit <= sat_sum.hit;
            end
            AS_MUL: begin
                r_prod <= r_a * r_b;
            end
            AS_MULS: begin
                r_res <= sat_mul.val;
                r_hit <= sat_mul.hit;
            end
            AS_DIV: begin
                if (r_divz) begin
                    r_res <= '0;
                    r_hit <= 1'b0;
                end else begin
                    r_rem <= ge ? 32'(rem_sh - {1'b0, r_d}) : rem_sh[31:0];
                    r_q   <= {r_q[NW-2:0], ge};
                    r_cnt <= r_cnt - DCW'(1);
                end
            end
            AS_DIVF: begin
                r_res <= sat_div.val;
                r_hit <= sat_div.hit;
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_hit;
    assign o_rsp.divz = r_divz;
    assign o_result   = r_res;

endmodule

[rtl/core/rpn_stack_evaluator.sv]
// Postfix (RPN) expression evaluator, signed fixed point, FRAC_BITS fraction bits.
// Input channel i_in carries one character per item plus a last flag.
// '1'..'9' push a digit; '+', '-', '*', '/' pop two and push the result
// (second popped op first popped). Anything else is an unknown token.
// On an item with last set, one item leaves on o_out: top of stack, status
// (ok, underflow, overflow, divide by zero, unknown token) and a sticky
// saturated flag; the stack and error state then clear for the next expression.
// The first error is sticky; later tokens up to last are dropped.
// Per input item: digits, rejected tokens and tokens after an error are handled
// in the idle state. An operator is accepted, waits in S_RD for the stack RAM
// read of the entry under the top, then runs on the shared ALU in S_EXEC:
// add/sub, multiply, or divide (one quotient bit per cycle in the restoring
// divider; a zero divisor skips the quotient loop). A last item then passes to
// the finish state to load the output register.
// i_in.ready is high only while the sequencer is idle. If o_out is stalled
// with a result still held, the next result waits in the finish state and
// input stays blocked until the output register frees up.
// Reset clears the stack count, error and clamp state; stack RAM content is
// not cleared, and no entry is used before it is written.
module rpn_stack_evaluator
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rse_in_if.sink       i_in,
    rse_out_if.source    o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;  // RAM read of second operand
    localparam logic [1:0] S_EXEC = 2'd2;  // ALU running
    localparam logic [1:0] S_FIN  = 2'd3;  // emit result

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_top,   n_top;    // top of stack lives in a register
    logic [2:0]    r_err,   n_err;
    logic          r_clamp, n_clamp;
    logic          r_last,  n_last;
    t_op           r_op,    n_op;

    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic [2:0]    r_ostat;
    logic          r_osat;

    logic          in_fire;
    logic          is_digit;
    logic          is_oper;
    t_op           tok_op;
    logic [3:0]    digit;
    t_sat          dig_sat;
    logic [1:0]    done_state;
    logic          out_load;
    logic [2:0]    fin_stat;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    logic [31:0]   alu_res;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // token decode
    assign is_digit = (i_in.token > TOK_ZERO) && (i_in.token <= TOK_NINE);
    assign is_oper  = (i_in.token == TOK_PLUS) || (i_in.token == TOK_MINUS) ||
                      (i_in.token == TOK_STAR) || (i_in.token == TOK_SLASH);
    assign digit    = i_in.token[3:0];
    assign dig_sat  = sat32($signed(65'(digit) << FRAC_BITS));

    always_comb begin
        case (i_in.token)
            TOK_PLUS:  tok_op = OP_ADD;
            TOK_MINUS: tok_op = OP_SUB;
            TOK_STAR:  tok_op = OP_MUL;
            default:   tok_op = OP_DIV;
        endcase
    end

    // RAM holds the entries below the top; the one under the top is count-2
    assign ram_waddr = AW'(r_count - CW'(1));
    assign ram_raddr = AW'(r_count - CW'(2));

    assign done_state = i_in.last ? S_FIN : S_IDLE;

    assign fin_stat = (r_err != ST_OK) ? r_err :
                      (r_count == '0)  ? ST_UNDER : ST_OK;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_top    = r_top;
        n_err    = r_err;
        n_clamp  = r_clamp;
        n_last   = r_last;
        n_op     = r_op;
        ram_we   = 1'b0;
        alu_req  = '0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_last  = i_in.last;
                    n_state = done_state;
                    if (r_err != ST_OK) begin
                        // sticky error: drop token
                    end else if (is_digit) begin
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_err = ST_OVER;
                        end else begin
                            ram_we  = (r_count != '0);   // spill old top
                            n_top   = dig_sat.val;
                            n_clamp = r_clamp | dig_sat.hit;
                            n_count = r_count + CW'(1);
                        end
                    end else if (!is_oper) begin
                        n_err = ST_UNKNOWN;
                    end else if (r_count < CW'(2)) begin
                        n_err = ST_UNDER;
                    end else begin
                        n_op    = tok_op;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                alu_req.start = 1'b1;
                alu_req.op    = r_op;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (alu_rsp.done) begin
                    n_top   = alu_res;
                    n_count = r_count - CW'(1);
                    n_clamp = r_clamp | alu_rsp.hit;
                    if (alu_rsp.divz) begin
                        n_err = ST_DIVZ;
                    end
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    out_load = 1'b1;
                    n_count  = '0;
                    n_err    = ST_OK;
                    n_clamp  = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= ST_OK;
            r_clamp  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            r_clamp <= n_clamp;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_last <= n_last;
        r_op   <= n_op;
        if (out_load) begin
            r_oval  <= (fin_stat == ST_OK) ? r_top : 32'd0;
            r_ostat <= fin_stat;
            r_osat  <= r_clamp;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.value     = r_oval;
    assign o_out.status    = r_ostat;
    assign o_out.saturated = r_osat;

    rse_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_top),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rse_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_top),
        .i_b      (ram_rdata),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    // ALU only finishes while the sequencer waits on it
    a_done_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_EXEC))
        else $error("ALU done outside exec state");

    // emitting a result clears the expression state
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_count == '0) && (r_err == ST_OK) && !r_clamp && o_out.valid)
        else $error("expression state not cleared after emit");

    // a good digit grows the stack by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_digit && (r_err == ST_OK) && (r_count < CW'(STACK_DEPTH)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not advance stack count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

endmodule

[bench/tb_rpn_stack_evaluator.sv]
`timescale 1ns / 100ps

module tb_rpn_stack_evaluator;
    import rse_pkg::*;

    localparam int DEPTH       = 16;
    localparam int FRAC        = 16;
    localparam int ITEM_TARGET = 1950;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 36;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         status;
        logic               saturated;
    } t_eval_result;

    typedef logic [7:0] t_tok_q[$];

    logic i_clk;
    logic i_rst_n;

    rse_in_if  in_if ();
    rse_out_if out_if ();

    rpn_stack_evaluator #(
        .STACK_DEPTH (DEPTH),
        .FRAC_BITS   (FRAC)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // expression state as the block should hold it
    logic signed [31:0] calc_stack [DEPTH];
    int unsigned        calc_depth;
    logic [2:0]         calc_err;
    logic               calc_clamp;

    t_eval_result pending_results[$];
    int           sent_tokens;   // items accepted by the block
    int           errors = 0;
    logic         calm;          // no idling on either side while set
    logic         hold_active = 1'b0;
    event         hold_ev;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // expression evaluator
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] clamp_q16(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            calc_clamp = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            calc_clamp = 1'b1;
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void eval_token(input logic [7:0] tok, input logic fin);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] r;
        t_eval_result       res;
        if (calc_err == ST_OK) begin
            if (tok > TOK_ZERO && tok <= TOK_NINE) begin
                if (calc_depth >= DEPTH) begin
                    calc_err = ST_OVER;
                end else begin
                    r = $signed({56'd0, 8'(tok - TOK_ZERO)}) <<< FRAC;
                    calc_stack[calc_depth] = clamp_q16(r);
                    calc_depth++;
                end
            end else if (tok != TOK_PLUS && tok != TOK_MINUS &&
                         tok != TOK_STAR && tok != TOK_SLASH) begin
                calc_err = ST_UNKNOWN;
            end else if (calc_depth < 2) begin
                calc_err = ST_UNDER;
            end else begin
                a = calc_stack[calc_depth - 1];   // top
                b = calc_stack[calc_depth - 2];
                calc_depth -= 2;
                case (tok)
                    TOK_PLUS:  r = b + a;
                    TOK_MINUS: r = b - a;
                    TOK_STAR:  r = (b * a) >>> FRAC;   // floor
                    default: begin
                        if (a == 0) begin
                            calc_err = ST_DIVZ;
                            r = 0;
                        end else begin
                            r = (b <<< FRAC) / a;      // truncates toward zero
                        end
                    end
                endcase
                calc_stack[calc_depth] = clamp_q16(r);
                calc_depth++;
            end
        end
        if (fin) begin
            res.status = calc_err;
            if (res.status == ST_OK && calc_depth == 0)
                res.status = ST_UNDER;
            res.value     = (res.status == ST_OK) ? calc_stack[calc_depth - 1] : 32'sd0;
            res.saturated = calc_clamp;
            pending_results.insert(pending_results.size(), res);
            calc_depth = 0;
            calc_err   = ST_OK;
            calc_clamp = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    task automatic send_token(input logic [7:0] tok, input logic fin);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.token <= tok;
        in_if.last  <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_tokens++;
        eval_token(tok, fin);
    endtask

    task automatic send_expr(input t_tok_q q);
        foreach (q[i]) send_token(q[i], i == q.size() - 1);
    endtask

    // drop valid and wait for every result still owed
    task automatic pause_input();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return TOK_ZERO + 8'($urandom_range(1, 9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return TOK_PLUS;
            1:       return TOK_MINUS;
            2:       return TOK_STAR;
            default: return TOK_SLASH;
        endcase
    endfunction

    // well-formed postfix, depth kept within the stack; sometimes forces a zero divisor
    function automatic t_tok_q build_wellformed(input int len);
        t_tok_q     q;
        int         d;
        logic [7:0] t;
        d = 0;
        for (int i = 0; i < len; i++) begin
            if (d < 2 || (d < DEPTH && $urandom_range(0, 1) == 1)) begin
                q.insert(q.size(), rand_digit());
                d++;
            end else if (d < DEPTH - 1 && $urandom_range(0, 19) == 0) begin
                t = rand_digit();
                q.insert(q.size(), t);
                q.insert(q.size(), t);
                q.insert(q.size(), TOK_MINUS);
                q.insert(q.size(), TOK_SLASH);
            end else begin
                q.insert(q.size(), rand_op());
                d--;
            end
        end
        return q;
    endfunction

    // mostly multiply chains so values run into the clamp, either sign
    function automatic t_tok_q build_growth();
        t_tok_q q;
        int     k;
        int     p;
        if ($urandom_range(0, 2) == 0) begin
            q.insert(q.size(), TOK_ZERO + 8'd1);
            q.insert(q.size(), rand_digit());
            q.insert(q.size(), TOK_MINUS);
        end else begin
            q.insert(q.size(), rand_digit());
        end
        k = $urandom_range(2, 9);
        for (int i = 0; i < k; i++) begin
            q.insert(q.size(), rand_digit());
            p = $urandom_range(0, 99);
            q.insert(q.size(), p < 70 ? TOK_STAR : p < 80 ? TOK_SLASH : rand_op());
        end
        return q;
    endfunction

    function automatic t_tok_q build_flood();
        t_tok_q q;
        int     n;
        n = DEPTH + $urandom_range(1, 3);
        for (int i = 0; i < n; i++) q.insert(q.size(), rand_digit());
        if ($urandom_range(0, 1) == 1) q.insert(q.size(), rand_op());
        return q;
    endfunction

    function automatic t_tok_q build_noise();
        t_tok_q q;
        int     n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom_range(0, 255)));
        return q;
    endfunction

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !hold_active && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // long receiver hold-off, counted here
    always begin
        @(hold_ev);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_eval_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual value %h status %0d",
                         $time, out_if.value, out_if.status);
            end else begin
                want = pending_results.pop_front();
                if (out_if.value !== want.value) begin
                    errors++;
                    $display("%0t: value mismatch expected %h actual %h",
                             $time, want.value, out_if.value);
                end
                if (out_if.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, out_if.status);
                end
                if (out_if.saturated !== want.saturated) begin
                    errors++;
                    $display("%0t: saturated mismatch expected %0b actual %0b",
                             $time, want.saturated, out_if.saturated);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_basic_ops();
        send_expr('{TOK_NINE});
        send_expr('{TOK_ZERO + 8'd8, TOK_ZERO + 8'd3, TOK_PLUS});
        send_expr('{TOK_ZERO + 8'd2, TOK_ZERO + 8'd7, TOK_MINUS});   // negative
        send_expr('{TOK_ZERO + 8'd3, TOK_ZERO + 8'd4, TOK_STAR});
        send_expr('{TOK_ZERO + 8'd7, TOK_ZERO + 8'd2, TOK_SLASH});   // fraction
        send_expr('{TOK_ZERO + 8'd3, TOK_ZERO + 8'd4});              // leftover operand
        pause_input();
    endtask

    task automatic test_error_codes();
        send_expr('{TOK_ZERO});                                       // zero is unknown
        send_expr('{TOK_ZERO + 8'd5, 8'h5E, 8'hFF});                  // power op, then dropped
        send_expr('{8'h00});
        send_expr('{TOK_PLUS});                                       // underflow
        send_expr('{TOK_ZERO + 8'd5, TOK_ZERO + 8'd5, TOK_ZERO + 8'd5,
                    TOK_MINUS, TOK_SLASH});                           // zero divisor
        pause_input();
    endtask

    // block fills up behind a stalled output and must hold off input
    task automatic test_output_backpressure();
        -> hold_ev;
        for (int i = 0; i < 12; i++) send_expr(build_wellformed($urandom_range(1, 4)));
        pause_input();
    endtask

    task automatic test_random_expressions();
        int     base;
        int     p;
        t_tok_q q;
        base = sent_tokens;
        while (sent_tokens < ITEM_TARGET) begin
            // one stretch with no idling on either side
            calm = (sent_tokens - base > 800 && sent_tokens - base < 1100);
            p = $urandom_range(0, 99);
            if (p < 60) begin
                q = build_wellformed($urandom_range(1, 24));
            end else if (p < 75) begin
                q = build_growth();
            end else if (p < 82) begin
                q = build_flood();
            end else if (p < 90) begin
                q = build_wellformed($urandom_range(1, 10));
                q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
            end else begin
                q = build_noise();
            end
            send_expr(q);
            if ($urandom_range(0, 49) == 0) pause_input();
        end
        calm = 1'b0;
        pause_input();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.token  = 8'h00;
        in_if.last   = 1'b0;
        calm         = 1'b0;
        sent_tokens  = 0;
        calc_depth   = 0;
        calc_err     = ST_OK;
        calc_clamp   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_error_codes();
        test_output_backpressure();
        test_random_expressions();

        // allow any straggler to show up before the verdict
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
